[hw/rtl/two_class_priority_queue_stats_defines.svh]
// Assertion macros for the two-class priority queue statistics block
`ifndef TWO_CLASS_PRIORITY_QUEUE_STATS_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_STATS_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define TCPQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpqs assertion failed");
// Next-cycle implication
`define TCPQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpqs assertion failed");
`else
`define TCPQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCPQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tcpqs_pkg.sv]
// Shared types and constants of the two-class priority queue statistics block
`default_nettype none
package tcpqs_pkg;

    localparam int LIM_W = 7;
    localparam int CNT_W = 32;
    localparam int SUM_W = 64;
    localparam int OCC_OUT_W = 7;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd49;

    // event commands
    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_DEPART = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // result outcomes
    localparam logic [2:0] OUT_SERVED   = 3'd0;
    localparam logic [2:0] OUT_QUEUED   = 3'd1;
    localparam logic [2:0] OUT_BLOCKED  = 3'd2;
    localparam logic [2:0] OUT_NEXT     = 3'd3;
    localparam logic [2:0] OUT_DEP_IDLE = 3'd4;
    localparam logic [2:0] OUT_IDLE_DEP = 3'd5;
    localparam logic [2:0] OUT_STAT     = 3'd6;

    // statistic kinds (index is kind * 2 + class)
    localparam logic [3:0] KIND_SOJ_SUM = 4'd4;
    localparam logic [3:0] KIND_SYS_OCC = 4'd8;
    localparam logic [3:0] KIND_Q_OCC   = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic upd;
    } t_dp_ctl;

    typedef struct packed {
        logic out_free;
        logic cmd_none;
    } t_dp_sts;

endpackage
`default_nettype wire

[hw/rtl/tcpqs_evt_if.sv]
// Event channel interface: valid, ready and one event item
`default_nettype none
interface tcpqs_evt_if #(
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic                  priority_class;
    logic [TIME_WIDTH-1:0] evt_stamp;
    logic [4:0]            stat_index;

    modport source (output valid, cmd, priority_class, evt_stamp, stat_index, input ready);
    modport sink   (input valid, cmd, priority_class, evt_stamp, stat_index, output ready);
endinterface
`default_nettype wire

[hw/rtl/tcpqs_res_if.sv]
// Result channel interface: valid, ready and one result item
`default_nettype none
interface tcpqs_res_if #(
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            outcome;
    logic                  departed_class;
    logic [TIME_WIDTH-1:0] sojourn_time;
    logic                  started_class;
    logic [TIME_WIDTH-1:0] started_wait;
    logic [6:0]            in_system;
    logic [6:0]            in_queue;
    logic [63:0]           stat_value;

    modport source (output valid, outcome, departed_class, sojourn_time, started_class,
                    started_wait, in_system, in_queue, stat_value, input ready);
    modport sink   (input valid, outcome, departed_class, sojourn_time, started_class,
                    started_wait, in_system, in_queue, stat_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/tcpqs_ctrl.sv]
// Controller state machine: accept, multiply, update sequencing
`default_nettype none
module tcpqs_ctrl
    import tcpqs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output t_dp_ctl      o_ctl
);

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_sts.cmd_none) n_state = S_MUL;
            end
            S_MUL: n_state = S_UPD;
            S_UPD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // drive datapath commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_ctl.capture = o_in_ready && i_in_valid;
    assign o_ctl.mul     = (r_state == S_MUL);
    assign o_ctl.upd     = (r_state == S_UPD) && i_sts.out_free;

endmodule
`default_nettype wire

[hw/rtl/tcpqs_dp.sv]
// Datapath: class queues, server entry, counters, sums and result register
`default_nettype none
module tcpqs_dp
    import tcpqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_ctl               i_ctl,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_we,
    input  wire logic [LIM_W-1:0]      i_cfg_wdata,
    input  wire logic [1:0]            i_cmd,
    input  wire logic                  i_cls,
    input  wire logic [TIME_WIDTH-1:0] i_time,
    input  wire logic [4:0]            i_idx,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [2:0]                 o_outcome,
    output logic                       o_dep_cls,
    output logic [TIME_WIDTH-1:0]      o_soj,
    output logic                       o_st_cls,
    output logic [TIME_WIDTH-1:0]      o_wait,
    output logic [OCC_OUT_W-1:0]       o_in_sys,
    output logic [OCC_OUT_W-1:0]       o_in_q,
    output logic [SUM_W-1:0]           o_stat
);

    localparam int TW = TIME_WIDTH;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OW = $clog2(QUEUE_DEPTH + 2);
    localparam int XW = (CW > LIM_W) ? CW : LIM_W;
    localparam int PW = TW + OW;
    localparam int EW = (PW > SUM_W) ? PW : SUM_W;
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [XW-1:0] DEPTH_X  = XW'(QUEUE_DEPTH);
    localparam logic [EW-1:0] SAT_E    = EW'({SUM_W{1'b1}});

    // captured item and configuration
    logic [1:0]       r_cmd;
    logic             r_cls;
    logic [TW-1:0]    r_now;
    logic [4:0]       r_idx;
    logic [LIM_W-1:0] r_limit;

    // queue and server state
    logic [TW-1:0] mem_q0 [QUEUE_DEPTH];
    logic [TW-1:0] mem_q1 [QUEUE_DEPTH];
    logic [TW-1:0] r_rd   [2];
    logic [AW-1:0] r_head [2];
    logic [AW-1:0] r_tail [2];
    logic [CW-1:0] r_cnt_q [2];
    logic [OW-1:0] r_occ_sys [2];
    logic          r_busy;
    logic [TW-1:0] r_svc_t;
    logic          r_svc_cls;
    logic [TW-1:0] r_last_t;
    logic [CNT_W-1:0] r_evt_cnt [8];
    logic [SUM_W-1:0] r_sum [8];

    // multiply stage results
    logic [SUM_W-1:0] r_area [4];
    logic [TW-1:0]    r_soj;
    logic [TW-1:0]    r_wait;
    logic [TW-1:0]    r_head_t;
    logic             r_hc;

    // result register
    logic             r_out_valid;
    logic [2:0]       r_outcome;
    logic             r_dep_cls;
    logic [TW-1:0]    r_soj_out;
    logic             r_st_cls;
    logic [TW-1:0]    r_wait_out;
    logic [OCC_OUT_W-1:0] r_in_sys;
    logic [OCC_OUT_W-1:0] r_in_q;
    logic [SUM_W-1:0] r_stat;

    // combinational
    logic [TW-1:0]    elapsed;
    logic [PW-1:0]    prod [4];
    logic [EW-1:0]    prod_e [4];
    logic [OW-1:0]    occ_mul [4];
    logic             is_arr, is_dep, is_rd, adv;
    logic [XW-1:0]    q_total;
    logic             full, serve_now, enq, blk, dep, start, go_idle;
    logic             wr_q [2];
    logic [OW-1:0]    n_occ_sys [2];
    logic [CW-1:0]    n_cnt_q [2];
    logic [7:0]       inc;
    logic [SUM_W-1:0] addend [8];
    logic [SUM_W:0]   sum_ext [8];
    logic [2:0]       n_outcome;
    logic [SUM_W-1:0] n_stat;
    logic [3:0]       kind;
    logic [OW-1:0]    sys_total;
    logic [CW-1:0]    q_new_total;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.cmd_none = (i_cmd == CMD_NONE);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_limit <= LIMIT_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_cls <= i_cls;
            r_now <= i_time;
            r_idx <= i_idx;
        end
    end

    // multiply stage: elapsed time times occupancy, sojourn and wait
    assign elapsed    = (r_now >= r_last_t) ? r_now - r_last_t : '0;
    assign occ_mul[0] = r_occ_sys[0];
    assign occ_mul[1] = r_occ_sys[1];
    assign occ_mul[2] = OW'(r_cnt_q[0]);
    assign occ_mul[3] = OW'(r_cnt_q[1]);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]   = PW'(occ_mul[k]) * PW'(elapsed);
            prod_e[k] = EW'(prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            for (int k = 0; k < 4; k++) begin
                r_area[k] <= (prod_e[k] > SAT_E) ? '1 : prod_e[k][SUM_W-1:0];
            end
            r_soj    <= (r_now >= r_svc_t) ? r_now - r_svc_t : '0;
            r_hc     <= (r_cnt_q[0] == '0);
            r_head_t <= (r_cnt_q[0] != '0) ? r_rd[0] : r_rd[1];
            r_wait   <= (r_cnt_q[0] != '0)
                        ? ((r_now >= r_rd[0]) ? r_now - r_rd[0] : '0)
                        : ((r_now >= r_rd[1]) ? r_now - r_rd[1] : '0);
        end
    end

    // decode the event
    assign is_arr    = (r_cmd == CMD_ARRIVE);
    assign is_dep    = (r_cmd == CMD_DEPART);
    assign is_rd     = (r_cmd == CMD_READ);
    assign adv       = is_arr || is_dep;
    assign q_total   = XW'(r_cnt_q[0]) + XW'(r_cnt_q[1]);
    assign full      = (q_total >= XW'(r_limit)) || (q_total >= DEPTH_X);
    assign serve_now = is_arr && !r_busy;
    assign enq       = is_arr && r_busy && !full;
    assign blk       = is_arr && r_busy && full;
    assign dep       = is_dep && r_busy;
    assign start     = dep && (q_total != '0);
    assign go_idle   = dep && (q_total == '0);
    assign wr_q[0]   = i_ctl.upd && enq && !r_cls;
    assign wr_q[1]   = i_ctl.upd && enq && r_cls;

    // next occupancies, counter increments and sum addends
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_occ_sys[c] = r_occ_sys[c]
                + OW'((serve_now || enq) && (r_cls == c[0]))
                - OW'(dep && (r_svc_cls == c[0]));
            n_cnt_q[c] = r_cnt_q[c]
                + CW'(enq && (r_cls == c[0]))
                - CW'(start && (r_hc == c[0]));
        end
        inc = '0;
        if (is_arr) inc[{2'b00, r_cls}] = 1'b1;
        if (blk)    inc[{2'b10, r_cls}] = 1'b1;
        if (dep)    inc[{2'b01, r_svc_cls}] = 1'b1;
        if (start)  inc[{2'b11, r_hc}] = 1'b1;
        for (int k = 0; k < 8; k++) addend[k] = '0;
        if (adv) begin
            addend[4] = r_area[0];
            addend[5] = r_area[1];
            addend[6] = r_area[2];
            addend[7] = r_area[3];
        end
        if (dep)   addend[{2'b00, r_svc_cls}] = SUM_W'(r_soj);
        if (start) addend[{2'b01, r_hc}] = SUM_W'(r_wait);
        for (int k = 0; k < 8; k++) begin
            sum_ext[k] = {1'b0, r_sum[k]} + {1'b0, addend[k]};
        end
    end

    // outcome and statistic selection
    assign kind = r_idx[4:1];
    always_comb begin
        priority if (is_rd)     n_outcome = OUT_STAT;
        else if (serve_now)     n_outcome = OUT_SERVED;
        else if (enq)           n_outcome = OUT_QUEUED;
        else if (blk)           n_outcome = OUT_BLOCKED;
        else if (start)         n_outcome = OUT_NEXT;
        else if (go_idle)       n_outcome = OUT_DEP_IDLE;
        else                    n_outcome = OUT_IDLE_DEP;

        priority if (kind < KIND_SOJ_SUM) n_stat = SUM_W'(r_evt_cnt[r_idx[2:0]]);
        else if (!r_idx[4])               n_stat = r_sum[r_idx[2:0]];
        else if (kind == KIND_SYS_OCC)    n_stat = SUM_W'(r_occ_sys[r_idx[0]]);
        else if (kind == KIND_Q_OCC)      n_stat = SUM_W'(r_cnt_q[r_idx[0]]);
        else                              n_stat = '0;
    end

    assign sys_total   = n_occ_sys[0] + n_occ_sys[1];
    assign q_new_total = n_cnt_q[0] + n_cnt_q[1];

    // queue memories: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (wr_q[0]) mem_q0[r_tail[0]] <= r_now;
        r_rd[0] <= mem_q0[r_head[0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_q[1]) mem_q1[r_tail[1]] <= r_now;
        r_rd[1] <= mem_q1[r_head[1]];
    end

    // commit the event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_svc_t   <= '0;
            r_svc_cls <= 1'b0;
            r_last_t  <= '0;
            for (int c = 0; c < 2; c++) begin
                r_head[c]    <= '0;
                r_tail[c]    <= '0;
                r_cnt_q[c]   <= '0;
                r_occ_sys[c] <= '0;
            end
            for (int k = 0; k < 8; k++) begin
                r_evt_cnt[k] <= '0;
                r_sum[k]     <= '0;
            end
        end else if (i_ctl.upd) begin
            if (adv) r_last_t <= r_now;
            if (serve_now) begin
                r_busy    <= 1'b1;
                r_svc_t   <= r_now;
                r_svc_cls <= r_cls;
            end
            if (start) begin
                r_svc_t   <= r_head_t;
                r_svc_cls <= r_hc;
            end
            if (go_idle) r_busy <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_occ_sys[c] <= n_occ_sys[c];
                r_cnt_q[c]   <= n_cnt_q[c];
                if (wr_q[c]) begin
                    r_tail[c] <= (r_tail[c] == LAST_PTR) ? '0 : r_tail[c] + AW'(1);
                end
                if (start && (r_hc == c[0])) begin
                    r_head[c] <= (r_head[c] == LAST_PTR) ? '0 : r_head[c] + AW'(1);
                end
            end
            for (int k = 0; k < 8; k++) begin
                if (inc[k] && (r_evt_cnt[k] != '1)) r_evt_cnt[k] <= r_evt_cnt[k] + 1'b1;
                r_sum[k] <= sum_ext[k][SUM_W] ? '1 : sum_ext[k][SUM_W-1:0];
            end
        end
    end

    // result register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)       r_out_valid <= 1'b0;
        else if (i_ctl.upd) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_outcome  <= n_outcome;
            r_dep_cls  <= dep ? r_svc_cls : 1'b0;
            r_soj_out  <= dep ? r_soj : '0;
            r_st_cls   <= serve_now ? r_cls : (start ? r_hc : 1'b0);
            r_wait_out <= start ? r_wait : '0;
            r_in_sys   <= OCC_OUT_W'(sys_total);
            r_in_q     <= OCC_OUT_W'(q_new_total);
            r_stat     <= is_rd ? n_stat : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_outcome;
    assign o_dep_cls   = r_dep_cls;
    assign o_soj       = r_soj_out;
    assign o_st_cls    = r_st_cls;
    assign o_wait      = r_wait_out;
    assign o_in_sys    = r_in_sys;
    assign o_in_q      = r_in_q;
    assign o_stat      = r_stat;

endmodule
`default_nettype wire

[hw/rtl/two_class_priority_queue_stats.sv]
// Two-class priority queue statistics block: top level
//
// Event items enter on i_evt (valid/ready): arrival, departure or statistic
// read. Each event yields one result item on o_res (valid/ready); an item
// with the unused command is taken and dropped without a result.
// The waiting limit is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// An item is captured in the accept step, multiplied in the multiply step
// and committed to the state and result register in the update step.
// No new item is taken before the update step of the last one; each queue
// memory has one write and one registered read port per class.
// A stalled receiver holds the result register; the next item is still
// taken and waits in its update step until the result register frees.
// Reset (synchronous, active low) empties both class queues, idles the
// server, clears counters and sums and sets the waiting limit to 49.
`default_nettype none
`include "two_class_priority_queue_stats_defines.svh"
module two_class_priority_queue_stats
    import tcpqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    tcpqs_evt_if.sink             i_evt,
    tcpqs_res_if.source           o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [LIM_W-1:0] i_cfg_wdata
);

    t_dp_ctl ctl;
    t_dp_sts sts;
    logic    in_ready;

    tcpqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    tcpqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_evt.cmd),
        .i_cls       (i_evt.priority_class),
        .i_time      (i_evt.evt_stamp),
        .i_idx       (i_evt.stat_index),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_outcome   (o_res.outcome),
        .o_dep_cls   (o_res.departed_class),
        .o_soj       (o_res.sojourn_time),
        .o_st_cls    (o_res.started_class),
        .o_wait      (o_res.started_wait),
        .o_in_sys    (o_res.in_system),
        .o_in_q      (o_res.in_queue),
        .o_stat      (o_res.stat_value)
    );

    assign i_evt.ready = in_ready;

    // checks
    `TCPQS_ASSERT_IMP(a_q_le_sys, i_clk, i_rst_n, o_res.valid, o_res.in_queue <= o_res.in_system)
    `TCPQS_ASSERT_IMP(a_wait_only_next, i_clk, i_rst_n, o_res.valid && o_res.outcome != OUT_NEXT, o_res.started_wait == '0)
    `TCPQS_ASSERT_IMP(a_no_departure, i_clk, i_rst_n, o_res.valid && (o_res.outcome == OUT_SERVED || o_res.outcome == OUT_QUEUED || o_res.outcome == OUT_BLOCKED || o_res.outcome == OUT_IDLE_DEP || o_res.outcome == OUT_STAT), o_res.sojourn_time == '0 && o_res.departed_class == 1'b0)
    `TCPQS_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_evt.valid && i_evt.ready && i_evt.cmd != CMD_NONE, !i_evt.ready)

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for the two-class priority queue statistics block
`timescale 1ns / 1ps
module testbench;
    import tcpqs_pkg::*;

    localparam int QDEPTH = 64;
    localparam int TW = 48;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam logic [31:0] CNTMAX = 32'hFFFF_FFFF;
    localparam logic [63:0] SUMMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          cls;
        logic [TW-1:0] t;
        logic [4:0]    idx;
    } evt_t;

    typedef struct packed {
        logic [2:0]    outcome;
        logic          dcls;
        logic [TW-1:0] soj;
        logic          scls;
        logic [TW-1:0] wait_t;
        logic [6:0]    nsys;
        logic [6:0]    nq;
        logic [63:0]   stat;
    } res_t;

    typedef struct packed {
        logic          cls;
        logic [TW-1:0] t;
    } cust_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [LIM_W-1:0] i_cfg_wdata = '0;

    tcpqs_evt_if #(.TIME_WIDTH(TW)) evt ();
    tcpqs_res_if #(.TIME_WIDTH(TW)) res ();

    two_class_priority_queue_stats #(.QUEUE_DEPTH(QDEPTH), .TIME_WIDTH(TW)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt.sink),
        .o_res      (res.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    cust_t       waitq[$];
    cust_t       serving;
    logic        busy;
    int unsigned occ[4];
    logic [TW-1:0] last_t;
    logic [31:0] counts[8];
    logic [63:0] sums[8];
    int unsigned limit_reg;

    res_t pending[$];
    int   errors = 0;
    int   n_results = 0;
    int   cycles = 0;
    logic [TW-1:0] now_t = '0;
    int   outcome_seen[7];
    logic phase_burst = 1'b0;

    task automatic reset_model();
        waitq.delete();
        serving = '0;
        busy = 1'b0;
        foreach (occ[i]) occ[i] = 0;
        last_t = '0;
        foreach (counts[i]) counts[i] = '0;
        foreach (sums[i]) sums[i] = '0;
        limit_reg = LIMIT_RESET;
    endtask

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SUMMAX : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul(int unsigned a, logic [TW-1:0] d);
        logic [127:0] p;
        p = 128'(a) * 128'(d);
        return (p[127:64] != 0) ? SUMMAX : p[63:0];
    endfunction

    function automatic logic [TW-1:0] elapsed(logic [TW-1:0] a, logic [TW-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic void bump(int i);
        if (counts[i] != CNTMAX) counts[i] = counts[i] + 1;
    endfunction

    function automatic void advance_clock(logic [TW-1:0] t);
        logic [TW-1:0] d;
        d = elapsed(t, last_t);
        for (int c = 0; c < 2; c++) begin
            sums[4+c] = sat_add(sums[4+c], sat_mul(occ[c], d));
            sums[6+c] = sat_add(sums[6+c], sat_mul(occ[2+c], d));
        end
        last_t = t;
    endfunction

    // Compute the result of one event and update the predictor state
    function automatic bit predict_event(evt_t e, output res_t r);
        int unsigned lim, pos, kind;
        cust_t h;
        logic [TW-1:0] w;
        r = '0;
        if (e.cmd == CMD_NONE) return 0;
        if (e.cmd == CMD_ARRIVE) begin
            advance_clock(e.t);
            bump(0 + e.cls);
            lim = (limit_reg > QDEPTH) ? QDEPTH : limit_reg;
            if (!busy) begin
                serving = '{cls: e.cls, t: e.t};
                busy = 1'b1;
                occ[e.cls]++;
                r.outcome = OUT_SERVED;
                r.scls = e.cls;
            end else if (waitq.size() < lim) begin
                pos = waitq.size();
                while (pos > 0 && waitq[pos-1].cls > e.cls) pos--;
                waitq.insert(pos, '{cls: e.cls, t: e.t});
                occ[e.cls]++;
                occ[2+e.cls]++;
                r.outcome = OUT_QUEUED;
            end else begin
                bump(4 + e.cls);
                r.outcome = OUT_BLOCKED;
            end
        end else if (e.cmd == CMD_DEPART) begin
            advance_clock(e.t);
            if (!busy) begin
                r.outcome = OUT_IDLE_DEP;
            end else begin
                r.dcls = serving.cls;
                r.soj = elapsed(e.t, serving.t);
                bump(2 + serving.cls);
                if (occ[serving.cls] > 0) occ[serving.cls]--;
                sums[0+serving.cls] = sat_add(sums[0+serving.cls], 64'(r.soj));
                if (waitq.size() > 0) begin
                    h = waitq.pop_front();
                    w = elapsed(e.t, h.t);
                    if (occ[2+h.cls] > 0) occ[2+h.cls]--;
                    bump(6 + h.cls);
                    sums[2+h.cls] = sat_add(sums[2+h.cls], 64'(w));
                    serving = h;
                    r.outcome = OUT_NEXT;
                    r.scls = h.cls;
                    r.wait_t = w;
                end else begin
                    busy = 1'b0;
                    r.outcome = OUT_DEP_IDLE;
                end
            end
        end else begin
            kind = e.idx >> 1;
            if (kind < 4) r.stat = 64'(counts[kind*2 + e.idx[0]]);
            else if (kind < 8) r.stat = sums[(kind-4)*2 + e.idx[0]];
            else if (kind == 8) r.stat = 64'(occ[e.idx[0]]);
            else if (kind == 9) r.stat = 64'(occ[2+e.idx[0]]);
            r.outcome = OUT_STAT;
        end
        r.nsys = 7'(occ[0] + occ[1]);
        r.nq = 7'(occ[2] + occ[3]);
        return 1;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("ERROR result %0d: %s got %0h want %0h", n_results, what, got, want);
    endtask

    // Receiver: random stalls, compare each result with the oldest expectation
    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                if (pending.size() == 0) begin
                    report("unexpected result", 64'(res.outcome), 0);
                end else begin
                    res_t x;
                    x = pending.pop_front();
                    if (res.outcome !== x.outcome) report("outcome", 64'(res.outcome), 64'(x.outcome));
                    if (res.departed_class !== x.dcls) report("departed_class", 64'(res.departed_class), 64'(x.dcls));
                    if (res.sojourn_time !== x.soj) report("sojourn_time", 64'(res.sojourn_time), 64'(x.soj));
                    if (res.started_class !== x.scls) report("started_class", 64'(res.started_class), 64'(x.scls));
                    if (res.started_wait !== x.wait_t) report("started_wait", 64'(res.started_wait), 64'(x.wait_t));
                    if (res.in_system !== x.nsys) report("in_system", 64'(res.in_system), 64'(x.nsys));
                    if (res.in_queue !== x.nq) report("in_queue", 64'(res.in_queue), 64'(x.nq));
                    if (res.stat_value !== x.stat) report("stat_value", res.stat_value, x.stat);
                    if (x.outcome < 7) outcome_seen[x.outcome]++;
                end
                n_results++;
            end
            if (!i_rst_n) res.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 10) res.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 2 && res.ready) res.ready <= 1'b0;
            else res.ready <= ($urandom_range(0, 3) != 0) || (phase_burst);
        end
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("two_class_priority_queue_stats: mismatch");
            $finish;
        end
    end

    // Send one event item, then, outside burst phases, sometimes a random gap
    task automatic send_event(evt_t e, bit has_want = 0, res_t want = '0);
        res_t r;
        evt.valid <= 1'b1;
        evt.cmd <= e.cmd;
        evt.priority_class <= e.cls;
        evt.evt_stamp <= e.t;
        evt.stat_index <= e.idx;
        do @(posedge i_clk); while (!evt.ready);
        if (predict_event(e, r)) begin
            if (has_want && r != want) begin
                errors++;
                $display("ERROR predictor disagrees with table row for cmd %0d", e.cmd);
            end
            pending.insert(pending.size(), r);
        end
        if (!phase_burst && $urandom_range(0, 2) == 0) begin
            int gap;
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            evt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic idle_drop();
        evt.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] v);
        idle_drop();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = v;
        @(posedge i_clk);
    endtask

    function automatic evt_t mk(logic [1:0] c, logic k, logic [TW-1:0] t, logic [4:0] i);
        evt_t e;
        e.cmd = c; e.cls = k; e.t = t; e.idx = i;
        return e;
    endfunction

    function automatic res_t mkr(logic [2:0] o, logic [6:0] ns, logic [6:0] nq);
        res_t r;
        r = '0; r.outcome = o; r.nsys = ns; r.nq = nq;
        return r;
    endfunction

    // Random event with a random time step, sometimes backwards or a jump
    task automatic random_event(int arrive_pct);
        evt_t e;
        int p;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) now_t = now_t - TW'($urandom_range(0, 1000));
        else if ($urandom_range(0, 199) == 0) now_t = TW'({$urandom, $urandom});
        else now_t = now_t + TW'($urandom_range(0, 1 << 20));
        e.t = now_t;
        e.cls = $urandom_range(0, 1);
        e.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
        if (p < 2) e.cmd = CMD_NONE;
        else if (p < 12) e.cmd = CMD_READ;
        else if (p < 12 + arrive_pct) e.cmd = CMD_ARRIVE;
        else e.cmd = CMD_DEPART;
        send_event(e);
    endtask

    typedef struct {
        evt_t e;
        bit   has;
        res_t r;
    } row_t;

    initial begin
        row_t rows[$];
        res_t w;
        reset_model();
        evt.valid = 1'b0;
        evt.cmd = CMD_NONE;
        evt.priority_class = 1'b0;
        evt.evt_stamp = '0;
        evt.stat_index = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reset reads, idle departure, bad index, extremes
        rows.insert(rows.size(), '{mk(CMD_READ, 0, 0, 0), 1, mkr(OUT_STAT, 0, 0)});
        rows.insert(rows.size(), '{mk(CMD_READ, 1, 0, 19), 1, mkr(OUT_STAT, 0, 0)});
        rows.insert(rows.size(), '{mk(CMD_DEPART, 0, 10, 0), 1, mkr(OUT_IDLE_DEP, 0, 0)});
        rows.insert(rows.size(), '{mk(CMD_READ, 0, 10, 31), 1, mkr(OUT_STAT, 0, 0)});
        rows.insert(rows.size(), '{mk(CMD_NONE, 1, TMAX, 31), 0, '0});
        w = mkr(OUT_SERVED, 1, 0); w.scls = 1;
        rows.insert(rows.size(), '{mk(CMD_ARRIVE, 1, 20, 0), 1, w});
        rows.insert(rows.size(), '{mk(CMD_ARRIVE, 1, 30, 0), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_ARRIVE, 0, 40, 0), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_ARRIVE, 0, 35, 0), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_DEPART, 0, 25, 0), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_DEPART, 0, TMAX, 0), 0, '0});
        for (int i = 0; i < 20; i++) rows.insert(rows.size(), '{mk(CMD_READ, 0, TMAX, 5'(i)), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_DEPART, 1, TMAX, 0), 0, '0});
        rows.insert(rows.size(), '{mk(CMD_DEPART, 1, TMAX, 0), 0, '0});
        foreach (rows[i]) send_event(rows[i].e, rows[i].has, rows[i].r);
        now_t = '0;

        // Limit of zero: every arrival behind the server is blocked
        write_limit(7'd0);
        for (int i = 0; i < 30; i++) random_event(60);
        // Limit above depth, fill the queue
        write_limit(7'd127);
        for (int i = 0; i < 200; i++) random_event(80);
        // Lower the limit while customers wait
        write_limit(7'd3);
        for (int i = 0; i < 150; i++) random_event(50);
        write_limit(7'd64);
        phase_burst = 1'b1;
        for (int i = 0; i < 200; i++) random_event(60);
        phase_burst = 1'b0;
        write_limit(7'd1);
        for (int i = 0; i < 150; i++) random_event(50);
        write_limit(7'(LIMIT_RESET));
        for (int i = 0; i < 600; i++) random_event(48);
        write_limit(7'd65);
        for (int i = 0; i < 200; i++) random_event(75);
        write_limit(7'($urandom_range(0, 127)));
        for (int i = 0; i < 330; i++) random_event(45);
        // Drain the queue and read everything back
        for (int i = 0; i < 70; i++) send_event(mk(CMD_DEPART, 0, now_t, 0));
        for (int i = 0; i < 32; i++) send_event(mk(CMD_READ, 0, now_t, 5'(i)));

        idle_drop();
        $display("covered %0d results: served %0d queued %0d blocked %0d next %0d",
                 n_results, outcome_seen[0], outcome_seen[1], outcome_seen[2],
                 outcome_seen[3]);
        $display("idle after departure %0d, idle departures %0d, stat reads %0d",
                 outcome_seen[4], outcome_seen[5], outcome_seen[6]);
        if (errors == 0) begin
            $display("two_class_priority_queue_stats: match");
        end else begin
            $display("two_class_priority_queue_stats: mismatch");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tcpqs_pkg.sv
hw/rtl/tcpqs_evt_if.sv
hw/rtl/tcpqs_res_if.sv
hw/rtl/tcpqs_ctrl.sv
hw/rtl/tcpqs_dp.sv
hw/rtl/two_class_priority_queue_stats.sv
tb/sv/testbench.sv
